// File: design/assert_macros.svh
// Assertion macros shared by the allocator RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_AT(lbl, clk, rst_n, prop) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
	else $error("assertion failed");
`define ASSERT_NEVER(lbl, clk, rst_n, expr) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
	else $error("assertion failed");
`else
`define ASSERT_AT(lbl, clk, rst_n, prop)
`define ASSERT_NEVER(lbl, clk, rst_n, expr)
`endif
`endif

// File: design/fhla_pkg.sv
// Shared types and constants of the free hole list allocator.
package fhla_pkg;

	localparam int MAX_HOLES_DEF = 64;
	localparam int SIZE_BITS_DEF = 16;
	localparam int REQ_W         = 16;
	localparam int OFF_W         = 32;
	localparam int HOLES_W       = 7;
	localparam int MODE_W        = 2;

	// fit modes; any other code behaves as worst fit
	localparam logic [MODE_W-1:0] MODE_FIRST = 2'd0;
	localparam logic [MODE_W-1:0] MODE_BEST  = 2'd1;

	localparam logic KIND_ALLOC = 1'b0;

	typedef enum logic [1:0] {
		ST_ALLOC = 2'd0,
		ST_NOFIT = 2'd1,
		ST_FREED = 2'd2,
		ST_FULL  = 2'd3
	} status_t;

	typedef enum logic [1:0] {
		OP_NONE      = 2'd0,
		OP_REMOVE    = 2'd1,
		OP_PLACE_IN  = 2'd2,
		OP_PLACE_REM = 2'd3
	} op_t;

	// controller to datapath
	typedef struct packed {
		op_t     op;
		logic    push;
		status_t status;
	} cmd_t;

	// datapath to controller
	typedef struct packed {
		logic full;
		logic hit;
		logic split;
	} dp_sts_t;

	// one result item
	typedef struct packed {
		status_t             status;
		logic [OFF_W-1:0]    offset;
		logic [HOLES_W-1:0]  holes;
	} res_t;

endpackage

// File: design/fhla_cells.sv
// Datapath: row of hole cells with parallel compare, shift insert and shift remove.
`include "assert_macros.svh"
module fhla_cells #(
	parameter int MAX_HOLES = fhla_pkg::MAX_HOLES_DEF,
	parameter int SIZE_BITS = fhla_pkg::SIZE_BITS_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_wen,
	input  logic [fhla_pkg::MODE_W-1:0]   cfg_wdata,
	input  logic [fhla_pkg::REQ_W-1:0]    req_size,
	input  logic [fhla_pkg::OFF_W-1:0]    free_offset,
	input  fhla_pkg::cmd_t                cmd,
	output fhla_pkg::dp_sts_t             sts,
	output fhla_pkg::res_t                res
);
	localparam int CW = $clog2(MAX_HOLES + 1);
	localparam int SW = SIZE_BITS;
	localparam int OW = fhla_pkg::OFF_W;
	localparam int HW = fhla_pkg::HOLES_W;

	logic [SW-1:0]               sz_q  [MAX_HOLES];
	logic [OW-1:0]               off_q [MAX_HOLES];
	logic [CW-1:0]               count_q;
	logic [fhla_pkg::MODE_W-1:0] mode_q;
	logic [SW-1:0]               rem_sz_q;
	logic [OW-1:0]               rem_off_q;
	logic [OW-1:0]               found_off_q;

	logic [SW-1:0]      req_sz;
	logic [SW+15:0]     req_ext;
	logic [SW+31:0]     req_off_ext;
	logic [CW+HW-1:0]   holes_ext;
	logic [CW-1:0]      count_nx;
	logic [SW-1:0]      new_sz;
	logic [OW-1:0]      new_off;
	logic [SW-1:0]      found_sz;
	logic [OW-1:0]      found_off;
	logic               placing;

	logic [MAX_HOLES-1:0] cell_v, hit, hpre, hsel, cond, mpre, shift_dn;
	logic [SW-1:0]        up_sz  [MAX_HOLES];
	logic [OW-1:0]        up_off [MAX_HOLES];
	logic [SW-1:0]        dn_sz  [MAX_HOLES];
	logic [OW-1:0]        dn_off [MAX_HOLES];

	// request size taken modulo 2^SW
	assign req_ext     = {{SW{1'b0}}, req_size};
	assign req_sz      = req_ext[SW-1:0];
	assign req_off_ext = {32'b0, req_sz};

	assign placing = (cmd.op == fhla_pkg::OP_PLACE_IN) || (cmd.op == fhla_pkg::OP_PLACE_REM);
	assign new_sz  = (cmd.op == fhla_pkg::OP_PLACE_REM) ? rem_sz_q  : req_sz;
	assign new_off = (cmd.op == fhla_pkg::OP_PLACE_REM) ? rem_off_q : free_offset;

	// per-cell compare, first-hit and insert-point prefixes
	genvar i;
	generate
		for (i = 0; i < MAX_HOLES; i++) begin : g_cell
			assign cell_v[i] = CW'(i) < count_q;
			assign hit[i]    = cell_v[i] && (sz_q[i] >= req_sz);
			assign cond[i]   = cell_v[i] && (mode_q != fhla_pkg::MODE_FIRST) &&
				((mode_q == fhla_pkg::MODE_BEST) ? (sz_q[i] >= new_sz) : (sz_q[i] <= new_sz));
			if (i == 0) begin : g_head
				assign hpre[i]     = hit[i];
				assign hsel[i]     = hit[i];
				assign mpre[i]     = cond[i] | ~cell_v[i];
				assign shift_dn[i] = 1'b0;
				assign dn_sz[i]    = new_sz;
				assign dn_off[i]   = new_off;
			end else begin : g_body
				assign hpre[i]     = hpre[i-1] | hit[i];
				assign hsel[i]     = hit[i] & ~hpre[i-1];
				assign mpre[i]     = mpre[i-1] | cond[i] | ~cell_v[i];
				assign shift_dn[i] = mpre[i-1];
				assign dn_sz[i]    = sz_q[i-1];
				assign dn_off[i]   = off_q[i-1];
			end
			if (i == MAX_HOLES - 1) begin : g_tail
				assign up_sz[i]  = sz_q[i];
				assign up_off[i] = off_q[i];
			end else begin : g_mid
				assign up_sz[i]  = sz_q[i+1];
				assign up_off[i] = off_q[i+1];
			end

			// cell update: close the gap on remove, open one on insert
			always_ff @(posedge clk) begin
				case (cmd.op)
					fhla_pkg::OP_REMOVE: begin
						if (hpre[i]) begin
							sz_q[i]  <= up_sz[i];
							off_q[i] <= up_off[i];
						end
					end
					fhla_pkg::OP_PLACE_IN, fhla_pkg::OP_PLACE_REM: begin
						if (mpre[i]) begin
							sz_q[i]  <= shift_dn[i] ? dn_sz[i]  : new_sz;
							off_q[i] <= shift_dn[i] ? dn_off[i] : new_off;
						end
					end
					default: begin
					end
				endcase
			end
		end
	endgenerate

	// one-hot select of the first fitting hole
	always_comb begin
		found_sz  = '0;
		found_off = '0;
		for (int k = 0; k < MAX_HOLES; k++) begin
			found_sz  = found_sz  | (sz_q[k]  & {SW{hsel[k]}});
			found_off = found_off | (off_q[k] & {OW{hsel[k]}});
		end
	end

	assign sts.full  = count_q >= CW'(MAX_HOLES);
	assign sts.hit   = hpre[MAX_HOLES-1];
	assign sts.split = found_sz > req_sz;

	// hole count after this command
	always_comb begin
		case (cmd.op)
			fhla_pkg::OP_REMOVE:    count_nx = count_q - CW'(1);
			fhla_pkg::OP_PLACE_IN,
			fhla_pkg::OP_PLACE_REM: count_nx = count_q + CW'(1);
			default:                count_nx = count_q;
		endcase
	end

	// result item
	assign holes_ext  = {{HW{1'b0}}, count_nx};
	assign res.status = cmd.status;
	assign res.holes  = holes_ext[HW-1:0];
	assign res.offset = (cmd.status != fhla_pkg::ST_ALLOC) ? '0 :
		((cmd.op == fhla_pkg::OP_PLACE_REM) ? found_off_q : found_off);

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			mode_q  <= fhla_pkg::MODE_FIRST;
		end else begin
			count_q <= count_nx;
			if (cfg_wen) begin
				mode_q <= cfg_wdata;
			end
		end
	end

	// remainder of a split hole, placed in the next cycle
	always_ff @(posedge clk) begin
		if (cmd.op == fhla_pkg::OP_REMOVE) begin
			rem_sz_q    <= found_sz - req_sz;
			rem_off_q   <= found_off + req_off_ext[OW-1:0];
			found_off_q <= found_off;
		end
	end

	`ASSERT_NEVER(a_count_range, clk, arst_n, count_q > CW'(MAX_HOLES))
	`ASSERT_NEVER(a_place_full, clk, arst_n, placing && sts.full)
	`ASSERT_NEVER(a_remove_miss, clk, arst_n, (cmd.op == fhla_pkg::OP_REMOVE) && !sts.hit)

endmodule

// File: design/fhla_ctrl.sv
// Controller: sequences allocate, free and remainder re-insert.
`include "assert_macros.svh"
module fhla_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	input  logic               kind,
	input  logic               spare_full,
	input  fhla_pkg::dp_sts_t  sts,
	output logic               in_ready,
	output fhla_pkg::cmd_t     cmd
);
	typedef enum logic [1:0] {
		S_IDLE  = 2'b01,
		S_SPLIT = 2'b10
	} state_t;

	state_t state_q, state_nx;
	logic   accept;

	assign in_ready = (state_q == S_IDLE) && !spare_full;
	assign accept   = in_valid && in_ready;

	// next state and command decode
	always_comb begin
		state_nx   = state_q;
		cmd.op     = fhla_pkg::OP_NONE;
		cmd.push   = 1'b0;
		cmd.status = fhla_pkg::ST_NOFIT;
		case (state_q)
			S_IDLE: begin
				if (accept) begin
					if (kind == fhla_pkg::KIND_ALLOC) begin
						if (!sts.hit) begin
							cmd.push   = 1'b1;
							cmd.status = fhla_pkg::ST_NOFIT;
						end else begin
							cmd.op     = fhla_pkg::OP_REMOVE;
							cmd.status = fhla_pkg::ST_ALLOC;
							if (sts.split) begin
								state_nx = S_SPLIT;
							end else begin
								cmd.push = 1'b1;
							end
						end
					end else if (sts.full) begin
						cmd.push   = 1'b1;
						cmd.status = fhla_pkg::ST_FULL;
					end else begin
						cmd.op     = fhla_pkg::OP_PLACE_IN;
						cmd.push   = 1'b1;
						cmd.status = fhla_pkg::ST_FREED;
					end
				end
			end
			S_SPLIT: begin
				cmd.op     = fhla_pkg::OP_PLACE_REM;
				cmd.push   = 1'b1;
				cmd.status = fhla_pkg::ST_ALLOC;
				state_nx   = S_IDLE;
			end
			default: begin
				state_nx = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_nx;
		end
	end

	`ASSERT_AT(a_split_one_cycle, clk, arst_n, (state_q == S_SPLIT) |=> (state_q == S_IDLE))

endmodule

// File: design/fhla_outbuf.sv
// Two-entry result buffer between the datapath and the output channel.
`include "assert_macros.svh"
module fhla_outbuf (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            push,
	input  fhla_pkg::res_t  din,
	input  logic            out_ready,
	output logic            out_valid,
	output fhla_pkg::res_t  dout,
	output logic            spare_full
);
	logic           out_v_q, sp_v_q;
	fhla_pkg::res_t out_q, sp_q;
	logic           pop;

	assign pop        = out_v_q && out_ready;
	assign out_valid  = out_v_q;
	assign dout       = out_q;
	assign spare_full = sp_v_q;

	// valid flags
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q <= 1'b0;
			sp_v_q  <= 1'b0;
		end else begin
			if (!out_v_q || pop) begin
				out_v_q <= sp_v_q || push;
				sp_v_q  <= 1'b0;
			end else if (push) begin
				sp_v_q <= 1'b1;
			end
		end
	end

	// payload
	always_ff @(posedge clk) begin
		if (!out_v_q || pop) begin
			out_q <= sp_v_q ? sp_q : din;
		end else if (push) begin
			sp_q <= din;
		end
	end

	`ASSERT_NEVER(a_push_overrun, clk, arst_n, push && sp_v_q)
	`ASSERT_NEVER(a_spare_alone, clk, arst_n, sp_v_q && !out_v_q)

endmodule

// File: design/free_hole_list_allocator.sv
// Free hole list allocator: first, best or worst fit over a row of hole cells.
// A free, a miss or an exact fit is pushed into the output buffer as accepted;
// a split stalls input while its split state re-inserts the remainder and pushes.
// Throughput: 1 item per cycle unless stalled; the single cell row is the limit.
// Reset: arst_n clears the hole count, fit mode (first fit) and the output buffer.
module free_hole_list_allocator #(
	parameter int MAX_HOLES = fhla_pkg::MAX_HOLES_DEF,
	parameter int SIZE_BITS = fhla_pkg::SIZE_BITS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_wen,
	input  logic [1:0]  cfg_wdata,     // fit_mode
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [47:0] s_tdata,       // req_size[15:0], free_offset[47:16]
	input  logic        s_tuser,       // kind
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [39:0] m_tdata,       // alloc_offset[31:0], holes_now[38:32], zero pad
	output logic [1:0]  m_tuser        // status
);
	fhla_pkg::cmd_t    cmd;
	fhla_pkg::dp_sts_t sts;
	fhla_pkg::res_t    res;
	fhla_pkg::res_t    dout;
	logic              spare_full;

	fhla_ctrl u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (s_tvalid),
		.kind       (s_tuser),
		.spare_full (spare_full),
		.sts        (sts),
		.in_ready   (s_tready),
		.cmd        (cmd)
	);

	fhla_cells #(
		.MAX_HOLES (MAX_HOLES),
		.SIZE_BITS (SIZE_BITS)
	) u_cells (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_wen     (cfg_wen),
		.cfg_wdata   (cfg_wdata),
		.req_size    (s_tdata[15:0]),
		.free_offset (s_tdata[47:16]),
		.cmd         (cmd),
		.sts         (sts),
		.res         (res)
	);

	fhla_outbuf u_outbuf (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (cmd.push),
		.din        (res),
		.out_ready  (m_tready),
		.out_valid  (m_tvalid),
		.dout       (dout),
		.spare_full (spare_full)
	);

	// output packing
	assign m_tdata = {1'b0, dout.holes, dout.offset};
	assign m_tuser = dout.status;

endmodule
